/* rtl/ttds_pkg.sv */
// Package for the timed target drill sequencer.
// Holds the shared types, codes and field widths; it depends on nothing.
package ttds_pkg;

    localparam int TARGET_W = 20;
    localparam int PTR_W    = 7;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int CFG_W    = 20;
    localparam int CIDX_W   = 3;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_START  = 3'd2,
        OP_RESUME = 3'd3,
        OP_STOP   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_PRESENT = 2'd0,
        KIND_HIDE    = 2'd1,
        KIND_DELAY   = 2'd2,
        KIND_PAUSE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RUN_IDLE   = 2'd0,
        RUN_ACTIVE = 2'd1,
        RUN_PAUSED = 2'd2
    } t_run;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_FIRE   = 2'd1,
        PH_TRAVEL = 2'd2
    } t_phase;

    localparam logic [CIDX_W-1:0] CFG_TARGET_SELECT = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_WORKING       = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_STEP_COUNT    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_FIRE_TIMEOUT  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_FACE_TRAVEL   = 3'd4;

    typedef struct packed {
        logic [TARGET_W-1:0] target_select;
        logic [TARGET_W-1:0] working_targets;
        logic [PTR_W-1:0]    step_count;
        logic [MS_W-1:0]     fire_timeout_ms;
        logic [MS_W-1:0]     face_travel_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] time_ms;
    } t_step;

    typedef struct packed {
        logic [2:0]          op;
        logic [5:0]          step_index;
        logic [1:0]          step_kind;
        logic [TIME_W-1:0]   step_time_ms;
        logic [TARGET_W-1:0] fired_targets;
        logic                queue_ready;
    } t_item;

    typedef struct packed {
        logic                command_valid;
        logic                command_face;
        logic [TARGET_W-1:0] command_targets;
        logic [1:0]          drill_state;
        logic                drill_finished;
        logic                finished_completed;
        logic                final_hide_dropped;
        logic                request_accepted;
    } t_result;

endpackage

/* rtl/ttds_cfg_regs.sv */
// Configuration register file of the drill sequencer.
// Uses ttds_pkg for the register indexes and the t_cfg struct.
module ttds_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [ttds_pkg::CIDX_W-1:0] i_wr_index,
    input  logic [ttds_pkg::CFG_W-1:0]  i_wr_data,
    output ttds_pkg::t_cfg              o_cfg
);

    ttds_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_select   <= '0;
            r_cfg.working_targets <= '1;
            r_cfg.step_count      <= '0;
            r_cfg.fire_timeout_ms <= 16'd600;
            r_cfg.face_travel_ms  <= '0;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                ttds_pkg::CFG_TARGET_SELECT: begin
                    r_cfg.target_select <= i_wr_data;
                end
                ttds_pkg::CFG_WORKING: begin
                    r_cfg.working_targets <= i_wr_data;
                end
                ttds_pkg::CFG_STEP_COUNT: begin
                    r_cfg.step_count <= i_wr_data[ttds_pkg::PTR_W-1:0];
                end
                ttds_pkg::CFG_FIRE_TIMEOUT: begin
                    r_cfg.fire_timeout_ms <= i_wr_data[ttds_pkg::MS_W-1:0];
                end
                ttds_pkg::CFG_FACE_TRAVEL: begin
                    r_cfg.face_travel_ms <= i_wr_data[ttds_pkg::MS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/ttds_step_mem.sv */
// Step store of the drill sequencer: one write port and one registered read port.
// A write to the address being read is forwarded. Uses ttds_pkg for t_step.
module ttds_step_mem #(
    parameter int STEP_DEPTH = 64,
    parameter int ADDR_W     = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  ttds_pkg::t_step   i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output ttds_pkg::t_step   o_rd_data
);

    ttds_pkg::t_step r_mem [STEP_DEPTH];
    ttds_pkg::t_step r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/ttds_ctrl.sv */
// Drill control: run state, step pointer, timers and the per-transaction result.
// Uses ttds_pkg; reads the step store through ttds_step_mem in the top level.
module ttds_ctrl #(
    parameter int STEP_DEPTH   = 64,
    parameter int TARGET_COUNT = 20,
    parameter int POLL_TICKS   = 5,
    parameter int ADDR_W       = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ttds_pkg::t_item   i_item,
    input  ttds_pkg::t_cfg    i_cfg,
    input  ttds_pkg::t_step   i_step,
    output logic              o_mem_wr_en,
    output logic [ADDR_W-1:0] o_mem_wr_addr,
    output ttds_pkg::t_step   o_mem_wr_data,
    output logic [ADDR_W-1:0] o_mem_rd_addr,
    output ttds_pkg::t_result o_result
);

    ttds_pkg::t_run                    r_run, n_run;
    ttds_pkg::t_phase                  r_phase, n_phase;
    logic [ttds_pkg::PTR_W-1:0]        r_ptr, n_ptr;
    logic [ttds_pkg::TIME_W-1:0]       r_wait, n_wait;
    logic [ttds_pkg::MS_W-1:0]         r_fired_wait, n_fired_wait;
    logic [2:0]                        r_poll, n_poll;
    logic [ttds_pkg::TARGET_W-1:0]     r_active, n_active;

    logic [ttds_pkg::TARGET_W-1:0]     all_mask;
    logic [ttds_pkg::TARGET_W-1:0]     start_mask;
    logic [ttds_pkg::PTR_W-1:0]        eff_count;
    logic [ttds_pkg::TIME_W-1:0]       wait_inc;
    logic [ttds_pkg::MS_W:0]           fired_sum;
    logic                              advance;
    logic                              fin;
    logic                              fin_done;
    logic                              fin_ready;

    always_comb begin
        for (int i = 0; i < ttds_pkg::TARGET_W; i++) begin
            all_mask[i] = (i < TARGET_COUNT);
        end
    end

    assign start_mask = ((i_cfg.target_select != '0) ? (i_cfg.target_select & all_mask)
                                                     : all_mask) & i_cfg.working_targets;
    assign eff_count  = (32'(i_cfg.step_count) > STEP_DEPTH) ?
                        ttds_pkg::PTR_W'(STEP_DEPTH) : i_cfg.step_count;
    assign wait_inc   = r_wait + 1'b1;
    assign fired_sum  = {1'b0, r_fired_wait} + (ttds_pkg::MS_W + 1)'(POLL_TICKS);

    always_comb begin
        n_run         = r_run;
        n_phase       = r_phase;
        n_ptr         = r_ptr;
        n_wait        = r_wait;
        n_fired_wait  = r_fired_wait;
        n_poll        = r_poll;
        n_active      = r_active;
        advance       = 1'b0;
        fin           = 1'b0;
        fin_done      = 1'b0;
        fin_ready     = 1'b0;
        o_result      = '0;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = ADDR_W'(i_item.step_index);
        o_mem_wr_data = '{kind: i_item.step_kind, time_ms: i_item.step_time_ms};

        if (i_accept) begin
            unique case (ttds_pkg::t_op'(i_item.op))
                ttds_pkg::OP_TICK: begin
                    if (r_run == ttds_pkg::RUN_ACTIVE) begin
                        if (r_ptr >= eff_count) begin
                            fin       = 1'b1;
                            fin_done  = 1'b1;
                            fin_ready = i_item.queue_ready;
                        end else begin
                            unique case (ttds_pkg::t_kind'(i_step.kind))
                                ttds_pkg::KIND_PRESENT: begin
                                    if (r_phase == ttds_pkg::PH_START) begin
                                        if (!i_item.queue_ready) begin
                                            fin = 1'b1;
                                        end else begin
                                            o_result.command_valid   = 1'b1;
                                            o_result.command_face    = 1'b1;
                                            o_result.command_targets = r_active;
                                            n_phase      = ttds_pkg::PH_FIRE;
                                            n_fired_wait = '0;
                                            n_poll       = '0;
                                        end
                                    end else if (r_phase == ttds_pkg::PH_FIRE) begin
                                        if (r_poll != '0) begin
                                            n_poll = r_poll - 1'b1;
                                        end else if ((i_item.fired_targets & r_active)
                                                     == r_active) begin
                                            if (i_cfg.face_travel_ms == '0) begin
                                                advance = 1'b1;
                                            end else begin
                                                n_phase = ttds_pkg::PH_TRAVEL;
                                                n_wait  = '0;
                                            end
                                        end else if (r_fired_wait >= i_cfg.fire_timeout_ms) begin
                                            fin       = 1'b1;
                                            fin_ready = i_item.queue_ready;
                                        end else begin
                                            n_poll       = 3'(POLL_TICKS - 1);
                                            n_fired_wait = fired_sum[ttds_pkg::MS_W] ?
                                                           '1 : fired_sum[ttds_pkg::MS_W-1:0];
                                        end
                                    end else begin
                                        n_wait = wait_inc;
                                        if (wait_inc >= 32'(i_cfg.face_travel_ms)) begin
                                            advance = 1'b1;
                                        end
                                    end
                                end
                                ttds_pkg::KIND_HIDE: begin
                                    if (!i_item.queue_ready) begin
                                        fin = 1'b1;
                                    end else begin
                                        o_result.command_valid   = 1'b1;
                                        o_result.command_targets = r_active;
                                        advance = 1'b1;
                                    end
                                end
                                ttds_pkg::KIND_DELAY: begin
                                    n_wait = wait_inc;
                                    if (wait_inc >= i_step.time_ms) begin
                                        advance = 1'b1;
                                    end
                                end
                                ttds_pkg::KIND_PAUSE: begin
                                    n_run = ttds_pkg::RUN_PAUSED;
                                end
                            endcase
                        end
                    end
                end
                ttds_pkg::OP_LOAD: begin
                    if ((r_run == ttds_pkg::RUN_IDLE) && (32'(i_item.step_index) < STEP_DEPTH)) begin
                        o_mem_wr_en = 1'b1;
                        o_result.request_accepted = 1'b1;
                    end
                end
                ttds_pkg::OP_START: begin
                    if ((r_run == ttds_pkg::RUN_IDLE) && (start_mask != '0)) begin
                        n_active     = start_mask;
                        n_run        = ttds_pkg::RUN_ACTIVE;
                        n_ptr        = '0;
                        n_phase      = ttds_pkg::PH_START;
                        n_wait       = '0;
                        n_fired_wait = '0;
                        n_poll       = '0;
                        o_result.request_accepted = 1'b1;
                    end
                end
                ttds_pkg::OP_RESUME: begin
                    if (r_run == ttds_pkg::RUN_PAUSED) begin
                        n_run   = ttds_pkg::RUN_ACTIVE;
                        advance = 1'b1;
                        o_result.request_accepted = 1'b1;
                    end
                end
                ttds_pkg::OP_STOP: begin
                    if (r_run != ttds_pkg::RUN_IDLE) begin
                        fin       = 1'b1;
                        fin_ready = i_item.queue_ready;
                        o_result.request_accepted = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (advance) begin
            n_ptr        = r_ptr + 1'b1;
            n_phase      = ttds_pkg::PH_START;
            n_wait       = '0;
            n_fired_wait = '0;
            n_poll       = '0;
        end

        if (fin) begin
            o_result.command_valid      = fin_ready;
            o_result.command_face       = 1'b0;
            o_result.command_targets    = fin_ready ? r_active : '0;
            o_result.drill_finished     = 1'b1;
            o_result.finished_completed = fin_done;
            o_result.final_hide_dropped = !fin_ready;
            n_run        = ttds_pkg::RUN_IDLE;
            n_phase      = ttds_pkg::PH_START;
            n_wait       = '0;
            n_fired_wait = '0;
            n_poll       = '0;
        end

        o_result.drill_state = n_run;
        o_mem_rd_addr        = ADDR_W'(n_ptr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= ttds_pkg::RUN_IDLE;
            r_phase      <= ttds_pkg::PH_START;
            r_ptr        <= '0;
            r_wait       <= '0;
            r_fired_wait <= '0;
            r_poll       <= '0;
            r_active     <= '0;
        end else begin
            r_run        <= n_run;
            r_phase      <= n_phase;
            r_ptr        <= n_ptr;
            r_wait       <= n_wait;
            r_fired_wait <= n_fired_wait;
            r_poll       <= n_poll;
            r_active     <= n_active;
        end
    end

endmodule

/* rtl/ttds_out_buf.sv */
// Two-entry result buffer: an output register and a skid register behind it.
// Uses ttds_pkg for the t_result struct.
module ttds_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ttds_pkg::t_result i_result,
    input  logic              i_out_stall,
    output logic              o_full,
    output logic              o_out_valid,
    output ttds_pkg::t_result o_result
);

    logic              r_main_valid, n_main_valid;
    logic              r_skid_valid, n_skid_valid;
    ttds_pkg::t_result r_main, n_main;
    ttds_pkg::t_result r_skid, n_skid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_main       = i_result;
                n_main_valid = i_accept;
            end
        end else if (i_accept) begin
            n_skid       = i_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_main_valid;
    assign o_result    = r_main;

endmodule

/* rtl/timed_target_drill_sequencer_unit.sv */
// Timed target drill sequencer, top level.
// Uses ttds_pkg, ttds_cfg_regs, ttds_step_mem, ttds_ctrl and ttds_out_buf.
//
// Usage: registers are written on the configuration channel (index and data,
// taken when i_cfg_valid and o_cfg_ready are high; o_cfg_ready is always high)
// while no drill transaction is outstanding. Requests and 1 ms ticks enter on
// the input channel and are taken when i_in_valid is high and o_in_stall is
// low. Every input transaction yields exactly one result on the output channel,
// taken when o_out_valid is high and i_out_stall is low.
// Each result is registered in the output register, or in the skid register
// while a stalled result holds it. Throughput is one transaction per cycle
// while o_in_stall is low, set by the state update and the prefetched step store read.
// When the receiver stalls, results collect in the output and skid registers;
// o_in_stall rises once both are full and falls when the output drains.
// Synchronous reset puts the drill in idle, empties the result buffer and
// restores the register defaults; the step store keeps its contents and must
// be loaded before a drill is started.
module timed_target_drill_sequencer_unit #(
    parameter int STEP_DEPTH   = 64,
    parameter int TARGET_COUNT = 20,
    parameter int POLL_TICKS   = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [5:0]  i_step_index,
    input  logic [1:0]  i_step_kind,
    input  logic [31:0] i_step_time_ms,
    input  logic [19:0] i_fired_targets,
    input  logic        i_queue_ready,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_command_valid,
    output logic        o_command_face,
    output logic [19:0] o_command_targets,
    output logic [1:0]  o_drill_state,
    output logic        o_drill_finished,
    output logic        o_finished_completed,
    output logic        o_final_hide_dropped,
    output logic        o_request_accepted,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    localparam int ADDR_W = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;

    ttds_pkg::t_cfg    cfg;
    ttds_pkg::t_item   item;
    ttds_pkg::t_step   rd_step;
    ttds_pkg::t_step   wr_step;
    ttds_pkg::t_result result;
    ttds_pkg::t_result out_result;
    logic              accept;
    logic              buf_full;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [ADDR_W-1:0] mem_rd_addr;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = buf_full;
    assign accept      = i_in_valid && !buf_full;

    assign item = '{op: i_op, step_index: i_step_index, step_kind: i_step_kind,
                    step_time_ms: i_step_time_ms, fired_targets: i_fired_targets,
                    queue_ready: i_queue_ready};

    ttds_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    ttds_step_mem #(
        .STEP_DEPTH (STEP_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (wr_step),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (rd_step)
    );

    ttds_ctrl #(
        .STEP_DEPTH   (STEP_DEPTH),
        .TARGET_COUNT (TARGET_COUNT),
        .POLL_TICKS   (POLL_TICKS),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (item),
        .i_cfg         (cfg),
        .i_step        (rd_step),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (wr_step),
        .o_mem_rd_addr (mem_rd_addr),
        .o_result      (result)
    );

    ttds_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_command_valid      = out_result.command_valid;
    assign o_command_face       = out_result.command_face;
    assign o_command_targets    = out_result.command_targets;
    assign o_drill_state        = out_result.drill_state;
    assign o_drill_finished     = out_result.drill_finished;
    assign o_finished_completed = out_result.finished_completed;
    assign o_final_hide_dropped = out_result.final_hide_dropped;
    assign o_request_accepted   = out_result.request_accepted;

endmodule
